// ----- src/mobility_binding_table_top_defines.svh -----
// Assertion macros for the mobility binding table checker
`ifndef MOBILITY_BINDING_TABLE_TOP_DEFINES_SVH
`define MOBILITY_BINDING_TABLE_TOP_DEFINES_SVH

// same-cycle implication, clocked by i_clk, off while i_rst_n is low
`define MBT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mbt_pkg.sv -----
// Types and constants shared by the mobility binding table
`timescale 1ns / 1ps

package mbt_pkg;

    localparam logic [1:0]  KIND_REGISTER = 2'd0;
    localparam logic [1:0]  KIND_LOOKUP   = 2'd1;
    localparam logic [1:0]  KIND_TICK     = 2'd2;

    localparam logic [2:0]  STAT_OK          = 3'd0;
    localparam logic [2:0]  STAT_UNSUPPORTED = 3'd1;
    localparam logic [2:0]  STAT_MALFORMED   = 3'd2;
    localparam logic [2:0]  STAT_UNKNOWN_HA  = 3'd3;
    localparam logic [2:0]  STAT_FULL        = 3'd4;

    localparam logic [15:0] LIFE_INFINITE  = 16'hffff;
    localparam logic [31:0] BROADCAST_ADDR = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0] home;
        logic [31:0] care_of;
        logic [15:0] life;
    } t_entry;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] dest;
        logic        found;
        logic [31:0] care_of;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

endpackage

// ----- src/mbt_if.sv -----
// Request and response channel interfaces
`timescale 1ns / 1ps

interface mbt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] home_address;
    logic [31:0] care_of_address;
    logic [15:0] requested_lifetime;
    logic [31:0] home_agent_address;
    logic [4:0]  service_flags;
    logic [1:0]  reserved_bits;

    modport source (output valid, kind, home_address, care_of_address, requested_lifetime,
                    home_agent_address, service_flags, reserved_bits, input ready);
    modport sink   (input valid, kind, home_address, care_of_address, requested_lifetime,
                    home_agent_address, service_flags, reserved_bits, output ready);
endinterface

interface mbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] reply_destination;
    logic        found;
    logic [31:0] care_of_result;
    logic        table_empty;
    logic [4:0]  entries_in_use;

    modport source (output valid, status, reply_destination, found, care_of_result,
                    table_empty, entries_in_use, input ready);
    modport sink   (input valid, status, reply_destination, found, care_of_result,
                    table_empty, entries_in_use, output ready);
endinterface

// ----- src/mbt_mem.sv -----
// Binding memory: one write port, one registered read port
`timescale 1ns / 1ps

module mbt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output mbt_pkg::t_entry  o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  mbt_pkg::t_entry  i_wr_data
);
    import mbt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/mbt_ctrl.sv -----
// Sequencer: scans the binding memory per transaction, updates it, builds the response
`timescale 1ns / 1ps

module mbt_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mbt_req_if.sink          i_req,
    mbt_rsp_if.source        o_rsp,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  mbt_pkg::t_entry  i_rd_data,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output mbt_pkg::t_entry  o_wr_data
);
    import mbt_pkg::*;

    t_state         r_state, n_state;
    logic [1:0]     r_kind, n_kind;
    logic [31:0]    r_home, n_home;
    logic [31:0]    r_coa, n_coa;
    logic [15:0]    r_life, n_life;
    logic [2:0]     r_chk, n_chk;
    logic [DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0]  r_count, n_count;
    logic [AW:0]    r_rd_idx, n_rd_idx;
    logic           r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]  r_cmp_idx, n_cmp_idx;
    logic           r_hit, n_hit;
    logic [AW-1:0]  r_hit_idx, n_hit_idx;
    t_entry         r_hit_ent, n_hit_ent;
    logic           r_free, n_free;
    logic [AW-1:0]  r_free_idx, n_free_idx;
    t_result        r_res, n_res;
    logic           r_out_valid, n_out_valid;
    t_result        r_out, n_out;
    logic           r_out_empty, n_out_empty;
    logic [4:0]     r_out_count, n_out_count;

    logic           w_accept;
    logic           w_scan;
    logic           w_last;
    logic           w_load;

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_home      <= n_home;
        r_coa       <= n_coa;
        r_life      <= n_life;
        r_chk       <= n_chk;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_ent   <= n_hit_ent;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_res       <= n_res;
        r_out       <= n_out;
        r_out_empty <= n_out_empty;
        r_out_count <= n_out_count;
    end

    assign w_last = r_cmp_vld && (r_cmp_idx == AW'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_SCAN;
            S_SCAN:  if (w_last) n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_scan      = (r_state == S_SCAN);
        w_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    end

    assign w_accept = i_req.valid && i_req.ready;

    always_comb begin
        n_kind      = r_kind;
        n_home      = r_home;
        n_coa       = r_coa;
        n_life      = r_life;
        n_chk       = r_chk;
        n_valid     = r_valid;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_ent   = r_hit_ent;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_out_empty = r_out_empty;
        n_out_count = r_out_count;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_rd_idx[AW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cmp_idx;
        o_wr_data   = i_rd_data;

        if (w_accept) begin
            n_kind   = i_req.kind;
            n_home   = i_req.home_address;
            n_coa    = i_req.care_of_address;
            n_life   = i_req.requested_lifetime;
            n_rd_idx = '0;
            n_hit    = 1'b0;
            n_free   = 1'b0;
            priority if (i_req.service_flags != '0) begin
                n_chk = STAT_UNSUPPORTED;
            end else if (i_req.reserved_bits != '0) begin
                n_chk = STAT_MALFORMED;
            end else if (i_req.home_agent_address == BROADCAST_ADDR) begin
                n_chk = STAT_UNKNOWN_HA;
            end else begin
                n_chk = STAT_OK;
            end
        end

        if (w_scan) begin
            if (r_rd_idx < (AW+1)'(DEPTH)) begin
                o_rd_en   = 1'b1;
                n_rd_idx  = r_rd_idx + (AW+1)'(1);
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_rd_idx[AW-1:0];
            end
            if (r_cmp_vld) begin
                if (r_kind == KIND_TICK) begin
                    if (r_valid[r_cmp_idx] && i_rd_data.life != LIFE_INFINITE) begin
                        if (i_rd_data.life <= 16'd1) begin
                            n_valid[r_cmp_idx] = 1'b0;
                            n_count            = r_count - CW'(1);
                        end else begin
                            o_wr_en        = 1'b1;
                            o_wr_data.life = i_rd_data.life - 16'd1;
                        end
                    end
                end else begin
                    if (r_valid[r_cmp_idx] && i_rd_data.home == r_home && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_ent = i_rd_data;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
            end
        end

        if (r_state == S_APPLY) begin
            n_res = '0;
            if (r_kind == KIND_REGISTER) begin
                n_res.status = r_chk;
                n_res.dest   = r_coa;
                n_res.found  = r_hit;
                if (r_hit) begin
                    if (r_life == '0) begin
                        n_res.dest = r_home;
                        if (r_chk == STAT_OK) begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_count            = r_count - CW'(1);
                        end
                    end else if (r_chk == STAT_OK) begin
                        o_wr_en        = 1'b1;
                        o_wr_addr      = r_hit_idx;
                        o_wr_data      = r_hit_ent;
                        o_wr_data.life = r_life;
                    end
                end else if (r_chk == STAT_OK && r_life != '0) begin
                    if (!r_free) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        n_valid[r_free_idx] = 1'b1;
                        n_count             = r_count + CW'(1);
                        o_wr_en             = 1'b1;
                        o_wr_addr           = r_free_idx;
                        o_wr_data.home      = r_home;
                        o_wr_data.care_of   = r_coa;
                        o_wr_data.life      = r_life;
                    end
                end
            end else if (r_kind == KIND_LOOKUP) begin
                n_res.found = r_hit;
                if (r_hit) begin
                    n_res.care_of = r_hit_ent.care_of;
                end
            end
        end

        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
            n_out_empty = (r_count == '0);
            n_out_count = 5'(r_count);
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.reply_destination = r_out.dest;
    assign o_rsp.found             = r_out.found;
    assign o_rsp.care_of_result    = r_out.care_of;
    assign o_rsp.table_empty       = r_out_empty;
    assign o_rsp.entries_in_use    = r_out_count;

endmodule

// ----- src/mobility_binding_table_top.sv -----
// Mobility binding table: home-agent binding store keyed by home address.
// Each transaction (registration, care-of lookup or one-second tick) walks
// every entry of the binding memory once, one entry per cycle through its
// single read port, then applies any update and builds the response; a
// tick updates entries during the walk itself. A new request is taken only
// after the previous response is built, as soon as it sits in the output
// register.
// No clearing pass is needed after reset: entry valid bits are flip-flops.
`timescale 1ns / 1ps

module mobility_binding_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbt_req_if.sink    i_req,
    mbt_rsp_if.source  o_rsp
);
    import mbt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic           w_rd_en;
    logic [AW-1:0]  w_rd_addr;
    t_entry         w_rd_data;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    t_entry         w_wr_data;

    mbt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    mbt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

// ----- src/mbt_checker.sv -----
// Port-level checks on the mobility binding table response channel
`timescale 1ns / 1ps
`include "mobility_binding_table_top_defines.svh"

module mbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_dest,
    input logic        i_found,
    input logic [31:0] i_coa,
    input logic        i_empty,
    input logic [4:0]  i_entries
);
    import mbt_pkg::*;

    `MBT_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_dest) && $stable(i_coa), "response dropped or changed while stalled")
    `MBT_ASSERT_IMPL(a_empty_count, i_out_valid && i_empty, i_entries == 5'd0, "empty table with nonzero count")
    `MBT_ASSERT_IMPL(a_status_range, i_out_valid, i_status <= STAT_FULL, "status code out of range")
    `MBT_ASSERT_IMPL(a_coa_on_hit, i_out_valid && (!i_found || i_status != STAT_OK), i_coa == 32'd0, "care-of result without lookup hit")

endmodule

bind mobility_binding_table_top mbt_checker u_mbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_dest      (o_rsp.reply_destination),
    .i_found     (o_rsp.found),
    .i_coa       (o_rsp.care_of_result),
    .i_empty     (o_rsp.table_empty),
    .i_entries   (o_rsp.entries_in_use)
);
